// File: rtl/core/adsr_envelope_level_assert.svh
// Assertion macros for the envelope level RTL.
`ifndef ADSR_ENVELOPE_LEVEL_ASSERT_SVH
`define ADSR_ENVELOPE_LEVEL_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ADSR_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adsr envelope check failed");

// Next-cycle implication, also checked around reset.
`define ADSR_AFTER(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("adsr envelope check failed");

`endif

// File: rtl/core/adsr_pkg.sv
package adsr_pkg;

  localparam int TIME_BITS = 32;
  localparam int LIFE_W    = TIME_BITS + 1;
  // signed width for time compares, holds the release clamp too
  localparam int EXT_W     = (LIFE_W > 27) ? LIFE_W : 27;
  localparam int CT_W      = 24;
  localparam int LVL_W     = 16;
  localparam int E_W       = 26;
  localparam int NUM_W     = 41;
  localparam int REM_W     = NUM_W - 1;
  localparam int DEN_W     = CT_W;
  localparam int Q_W       = 16;
  localparam int PADDR_W   = 5;
  localparam int NEG_CLAMP = 33554432;

  localparam logic [LVL_W:0] LEVEL_MAX = 17'd32768;

  typedef enum logic [2:0] {
    REG_ATTACK,
    REG_DECAY,
    REG_RELEASE,
    REG_SUSTAIN,
    REG_PEAK
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_ZERO,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN
  } phase_t;

  typedef struct packed {
    logic [CT_W-1:0]  attack;
    logic [CT_W-1:0]  decay;
    logic [CT_W-1:0]  release_t;
    logic [LVL_W-1:0] sustain;
    logic [LVL_W-1:0] peak;
  } cfg_t;

  // per-item side data that rides along the pipeline
  typedef struct packed {
    logic             held;
    phase_t           phase;
    logic             dec_neg;
    logic             rel_dead;
    logic             e_neg;
    logic [E_W-1:0]   e_mag;
    logic [LVL_W-1:0] ads;
  } ctx_t;

endpackage

// File: rtl/core/adsr_phase.sv
module adsr_phase import adsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [TIME_BITS-1:0] time_now,
  input  logic [TIME_BITS-1:0] note_on_time,
  input  logic [TIME_BITS-1:0] note_off_time,
  input  cfg_t                 cfg,
  output logic                 out_vld,
  output ctx_t                 out_ctx,
  output logic [NUM_W-1:0]     num,
  output logic [DEN_W-1:0]     den
);

  // stage 1: lifetime and elapsed release time
  logic                     held_c;
  logic signed [LIFE_W-1:0] life_c;
  logic signed [LIFE_W-1:0] e_c;
  logic                     v1;
  logic                     held1;
  logic signed [EXT_W-1:0]  life1;
  logic signed [EXT_W-1:0]  e1;

  always_comb begin
    held_c = note_on_time > note_off_time;
    if (held_c) begin
      life_c = {1'b0, time_now} - {1'b0, note_on_time};
    end else begin
      life_c = {1'b0, note_off_time} - {1'b0, note_on_time};
    end
    e_c = {1'b0, time_now} - {1'b0, note_off_time};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      held1 <= held_c;
      life1 <= life_c;
      e1    <= e_c;
    end
  end

  // stage 2: phase select and multiplier operands
  logic signed [EXT_W-1:0] a_x;
  logic signed [EXT_W-1:0] ad_x;
  logic signed [EXT_W-1:0] rt_x;
  logic signed [EXT_W-1:0] neg_lim;
  logic signed [EXT_W-1:0] life_m;
  ctx_t                    ctx_c;
  logic [CT_W-1:0]         ma_c;
  logic [LVL_W-1:0]        mb_c;
  logic [DEN_W-1:0]        den_c;
  logic                    v2;
  ctx_t                    ctx2;
  logic [CT_W-1:0]         ma2;
  logic [LVL_W-1:0]        mb2;
  logic [DEN_W-1:0]        den2;

  assign a_x     = EXT_W'(cfg.attack);
  assign ad_x    = EXT_W'(cfg.attack) + EXT_W'(cfg.decay);
  assign rt_x    = EXT_W'(cfg.release_t);
  assign neg_lim = -EXT_W'(NEG_CLAMP);
  assign life_m  = life1 - a_x;

  always_comb begin
    ctx_c         = '0;
    ctx_c.held    = held1;
    ctx_c.dec_neg = cfg.sustain < cfg.peak;
    ma_c          = '0;
    mb_c          = '0;
    den_c         = cfg.attack;
    if (life1 < 0) begin
      ctx_c.phase = PH_ZERO;
    end else if (life1 <= a_x) begin
      ctx_c.phase = PH_ATTACK;
      ma_c        = life1[CT_W-1:0];
      mb_c        = cfg.peak;
    end else if (life1 <= ad_x) begin
      ctx_c.phase = PH_DECAY;
      ma_c        = life_m[CT_W-1:0];
      mb_c        = ctx_c.dec_neg ? (cfg.peak - cfg.sustain) : (cfg.sustain - cfg.peak);
      den_c       = cfg.decay;
    end else begin
      ctx_c.phase = PH_SUSTAIN;
    end
    // release bookkeeping, the level it needs comes later
    ctx_c.rel_dead = (cfg.release_t == '0) || (e1 >= rt_x);
    ctx_c.e_neg    = e1 < 0;
    if (e1 < neg_lim) begin
      ctx_c.e_mag = E_W'(NEG_CLAMP);
    end else if (e1 < 0) begin
      ctx_c.e_mag = E_W'(-e1);
    end else begin
      ctx_c.e_mag = E_W'(e1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2 <= ctx_c;
      ma2  <= ma_c;
      mb2  <= mb_c;
      den2 <= den_c;
    end
  end

  // stage 3: ramp product
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= ctx2;
      num     <= NUM_W'(ma2) * NUM_W'(mb2);
      den     <= den2;
    end
  end

endmodule

// File: rtl/core/adsr_div.sv
module adsr_div import adsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  ctx_t             in_ctx,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             out_vld,
  output ctx_t             out_ctx,
  output logic [Q_W-1:0]   quot,
  output logic             ovf
);

  // one restoring step per stage, quotient bits shift in MSB first
  logic             vld_s [0:Q_W];
  ctx_t             ctx_s [0:Q_W];
  logic [REM_W-1:0] rem_s [0:Q_W];
  logic [Q_W-1:0]   q_s   [0:Q_W];
  logic [DEN_W-1:0] den_s [0:Q_W];
  logic             ovf_s [0:Q_W];
  logic             dz_s  [0:Q_W];
  logic             ovf_c;

  // load: quotient of 2^16 or more is flagged, not divided;
  // a zero divisor is left to the zero-quotient path
  assign ovf_c = (den != '0) && (num >= NUM_W'({den, {Q_W{1'b0}}}));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_s[0] <= in_ctx;
      rem_s[0] <= ovf_c ? '0 : num[REM_W-1:0];
      q_s[0]   <= '0;
      den_s[0] <= den;
      ovf_s[0] <= ovf_c;
      dz_s[0]  <= den == '0;
    end
  end

  for (genvar g = 0; g < Q_W; g++) begin : g_step
    localparam int SH = Q_W - 1 - g;
    logic [REM_W-1:0] sub_v;
    logic             ge;

    assign sub_v = REM_W'(den_s[g]) << SH;
    assign ge    = rem_s[g] >= sub_v;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else if (en) begin
        vld_s[g+1] <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_s[g+1] <= ctx_s[g];
        rem_s[g+1] <= ge ? (rem_s[g] - sub_v) : rem_s[g];
        q_s[g+1]   <= {q_s[g][Q_W-2:0], ge};
        den_s[g+1] <= den_s[g];
        ovf_s[g+1] <= ovf_s[g];
        dz_s[g+1]  <= dz_s[g];
      end
    end
  end

  // a zero divisor gives a zero quotient
  assign out_vld = vld_s[Q_W];
  assign out_ctx = ctx_s[Q_W];
  assign quot    = dz_s[Q_W] ? '0 : q_s[Q_W];
  assign ovf     = ovf_s[Q_W];

endmodule

// File: rtl/core/adsr_rel.sv
module adsr_rel import adsr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  ctx_t             in_ctx,
  input  logic [Q_W-1:0]   quot,
  input  cfg_t             cfg,
  output logic             out_vld,
  output ctx_t             out_ctx,
  output logic [NUM_W-1:0] num,
  output logic [DEN_W-1:0] den
);

  // stage A: attack-decay-sustain level from the ramp quotient
  logic [LVL_W-1:0] ads_c;
  ctx_t             ctx_c;
  ctx_t             ctx_a;
  logic             v_a;

  always_comb begin
    case (in_ctx.phase)
      PH_ZERO:    ads_c = '0;
      PH_ATTACK:  ads_c = quot;
      PH_DECAY:   ads_c = in_ctx.dec_neg ? (cfg.peak - quot) : (cfg.peak + quot);
      PH_SUSTAIN: ads_c = cfg.sustain;
      default:    ads_c = '0;
    endcase
    ctx_c     = in_ctx;
    ctx_c.ads = ads_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_a <= ctx_c;
    end
  end

  // stage B: elapsed release times note-off level
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= ctx_a;
      num     <= NUM_W'(ctx_a.e_mag) * NUM_W'(ctx_a.ads);
      den     <= cfg.release_t;
    end
  end

endmodule

// File: rtl/core/adsr_envelope_level.sv
// ADSR envelope level. Takes one (time_now, note_on_time, note_off_time) item
// per clock while not stalled and returns one level per item, in order. The
// path is a 3-stage front end (lifetime, phase, ramp product), a 17-stage
// divider for the attack/decay ramp, 2 stages for the note-off level and
// release product, a second 17-stage divider for the release ramp, and the
// output register. The whole pipe holds while out_stall holds a waiting
// result. Registers sit at APB byte addresses 0, 4, 8, 12, 16 (attack, decay,
// release, sustain, peak) and are to be written only while the pipe is empty.
module adsr_envelope_level import adsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_BITS-1:0] time_now,
  input  logic [TIME_BITS-1:0] note_on_time,
  input  logic [TIME_BITS-1:0] note_off_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LVL_W-1:0]     level,
  output logic                 silent,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  cfg_t     cfg;
  reg_idx_t idx;
  logic     en;

  // register file
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack    <= 24'd4410;
      cfg.decay     <= 24'd4410;
      cfg.release_t <= 24'd8820;
      cfg.sustain   <= 16'd32768;
      cfg.peak      <= 16'd32768;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ATTACK:  cfg.attack    <= pwdata[CT_W-1:0];
        REG_DECAY:   cfg.decay     <= pwdata[CT_W-1:0];
        REG_RELEASE: cfg.release_t <= pwdata[CT_W-1:0];
        REG_SUSTAIN: cfg.sustain   <= pwdata[LVL_W-1:0];
        REG_PEAK:    cfg.peak      <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ATTACK:  prdata = 32'(cfg.attack);
      REG_DECAY:   prdata = 32'(cfg.decay);
      REG_RELEASE: prdata = 32'(cfg.release_t);
      REG_SUSTAIN: prdata = 32'(cfg.sustain);
      REG_PEAK:    prdata = 32'(cfg.peak);
      default:     prdata = '0;
    endcase
  end

  // one pipe-wide advance
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic             ph_vld;
  ctx_t             ph_ctx;
  logic [NUM_W-1:0] ph_num;
  logic [DEN_W-1:0] ph_den;
  logic             d1_vld;
  ctx_t             d1_ctx;
  logic [Q_W-1:0]   d1_quot;
  logic             d1_ovf;
  logic             rl_vld;
  ctx_t             rl_ctx;
  logic [NUM_W-1:0] rl_num;
  logic [DEN_W-1:0] rl_den;
  logic             d2_vld;
  ctx_t             d2_ctx;
  logic [Q_W-1:0]   d2_quot;
  logic             d2_ovf;

  adsr_phase u_phase (
    .clk, .rst, .en,
    .in_vld (in_valid),
    .time_now, .note_on_time, .note_off_time,
    .cfg,
    .out_vld(ph_vld),
    .out_ctx(ph_ctx),
    .num    (ph_num),
    .den    (ph_den)
  );

  adsr_div u_div_ramp (
    .clk, .rst, .en,
    .in_vld (ph_vld),
    .in_ctx (ph_ctx),
    .num    (ph_num),
    .den    (ph_den),
    .out_vld(d1_vld),
    .out_ctx(d1_ctx),
    .quot   (d1_quot),
    .ovf    (d1_ovf)
  );

  adsr_rel u_rel (
    .clk, .rst, .en,
    .in_vld (d1_vld),
    .in_ctx (d1_ctx),
    .quot   (d1_quot),
    .cfg,
    .out_vld(rl_vld),
    .out_ctx(rl_ctx),
    .num    (rl_num),
    .den    (rl_den)
  );

  adsr_div u_div_rel (
    .clk, .rst, .en,
    .in_vld (rl_vld),
    .in_ctx (rl_ctx),
    .num    (rl_num),
    .den    (rl_den),
    .out_vld(d2_vld),
    .out_ctx(d2_ctx),
    .quot   (d2_quot),
    .ovf    (d2_ovf)
  );

  // final level, clamp and saturate
  logic [LVL_W:0]   amp;
  logic             sat;
  logic [LVL_W-1:0] level_c;
  logic             silent_c;

  always_comb begin
    amp = '0;
    sat = 1'b0;
    if (d2_ctx.held) begin
      amp = {1'b0, d2_ctx.ads};
    end else if (d2_ctx.rel_dead) begin
      amp = '0;
    end else if (d2_ctx.e_neg) begin
      // before note-off: level rises above the note-off level
      if (d2_ovf) begin
        sat = 1'b1;
      end else begin
        amp = {1'b0, d2_ctx.ads} + {1'b0, d2_quot};
      end
    end else begin
      amp = {1'b0, d2_ctx.ads} - {1'b0, d2_quot};
    end
    level_c  = (sat || amp > LEVEL_MAX) ? LEVEL_MAX[LVL_W-1:0] : amp[LVL_W-1:0];
    silent_c = !sat && (amp == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level  <= level_c;
      silent <= silent_c;
    end
  end

`include "adsr_envelope_level_assert.svh"

  `ADSR_IMPLIES(a_level_range, out_valid && !silent, level != '0 && {1'b0, level} <= LEVEL_MAX)
  `ADSR_IMPLIES(a_ramp_no_ovf, d1_vld, !d1_ovf)
  `ADSR_IMPLIES(a_ovf_only_early, d2_vld && d2_ovf && !d2_ctx.held && !d2_ctx.rel_dead, d2_ctx.e_neg)
  `ADSR_AFTER(a_reset_empty, rst, !out_valid)

endmodule
